// ----- rtl/core/uart_rx_ring_buffer_defines.svh -----
// ---------------------------------------------------------------------------
// UART receive ring buffer assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef UART_RX_RING_BUFFER_DEFINES_SVH
`define UART_RX_RING_BUFFER_DEFINES_SVH

`ifndef SYNTH
// Check a property on every clock edge outside reset
`define URRB_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("uart_rx_ring_buffer assertion failed");
// Check a property on every clock edge, reset included
`define URRB_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("uart_rx_ring_buffer assertion failed");
`else
`define URRB_ASSERT(lbl, prop)
`define URRB_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ----- rtl/core/urrb_pkg.sv -----
// ---------------------------------------------------------------------------
// urrb_pkg
// Shared widths, command codes and control structs of the receive buffer.
// ---------------------------------------------------------------------------
package urrb_pkg;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 7;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_READ = 1'b1
    } command_t;

    // controller -> datapath
    typedef struct packed {
        logic in_ready;
        logic push;
        logic read_idle;
        logic read_start;
        logic emit;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic in_valid;
        logic is_read;
        logic out_free;
        logic read_go;
        logic final_byte;
    } ctrl_sts_t;

endpackage

// ----- rtl/core/urrb_in_if.sv -----
// ---------------------------------------------------------------------------
// urrb_in_if
// Request channel: push a received byte or ask for a read.
// ---------------------------------------------------------------------------
interface urrb_in_if;

    logic                           valid;
    logic                           ready;
    logic                           command;
    logic [urrb_pkg::BYTE_W-1:0]    rx_byte;
    logic [urrb_pkg::COUNT_W-1:0]   read_count;

    modport source (output valid, output command, output rx_byte, output read_count,
                    input ready);
    modport sink   (input valid, input command, input rx_byte, input read_count,
                    output ready);

endinterface

// ----- rtl/core/urrb_out_if.sv -----
// ---------------------------------------------------------------------------
// urrb_out_if
// Result channel: one byte or status item with fill level and flags.
// ---------------------------------------------------------------------------
interface urrb_out_if;

    logic                           valid;
    logic                           ready;
    logic [urrb_pkg::BYTE_W-1:0]    data_byte;
    logic                           data_valid;
    logic                           last;
    logic [urrb_pkg::COUNT_W-1:0]   fill_level;
    logic                           overflowed;
    logic                           data_available;

    modport source (output valid, output data_byte, output data_valid, output last,
                    output fill_level, output overflowed, output data_available,
                    input ready);
    modport sink   (input valid, input data_byte, input data_valid, input last,
                    input fill_level, input overflowed, input data_available,
                    output ready);

endinterface

// ----- rtl/core/urrb_ram.sv -----
// ---------------------------------------------------------------------------
// urrb_ram
// Generic single write port RAM with one registered read port.
// ---------------------------------------------------------------------------
module urrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/urrb_ctrl.sv -----
// ---------------------------------------------------------------------------
// urrb_ctrl
// Sequencer: takes items while idle and walks a read one byte per cycle while the result side is free.
// ---------------------------------------------------------------------------
`include "uart_rx_ring_buffer_defines.svh"

module urrb_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  urrb_pkg::ctrl_sts_t   sts,
    output urrb_pkg::ctrl_cmd_t   cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    always_comb
    begin
        cmd.in_ready   = (state_reg == ST_IDLE) && sts.out_free;
        accept         = cmd.in_ready && sts.in_valid;
        cmd.push       = accept && !sts.is_read;
        cmd.read_idle  = accept && sts.is_read && !sts.read_go;
        cmd.read_start = accept && sts.is_read && sts.read_go;
        cmd.emit       = (state_reg == ST_EMIT) && sts.out_free;

        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.read_start)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (cmd.emit && sts.final_byte)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `URRB_ASSERT(a_read_enters_emit, cmd.read_start |=> state_reg == ST_EMIT)
    `URRB_ASSERT(a_no_item_mid_read, state_reg == ST_EMIT |-> !(sts.in_valid && cmd.in_ready))

endmodule

// ----- rtl/core/urrb_datapath.sv -----
// ---------------------------------------------------------------------------
// urrb_datapath
// Pointers, flags, byte store and the result register.
// ---------------------------------------------------------------------------
`include "uart_rx_ring_buffer_defines.svh"

module urrb_datapath #(
    parameter int DEPTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  urrb_pkg::ctrl_cmd_t   cmd,
    output urrb_pkg::ctrl_sts_t   sts,
    urrb_in_if.sink               request,
    urrb_out_if.source            result
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CW    = urrb_pkg::COUNT_W;
    localparam int BW    = urrb_pkg::BYTE_W;
    localparam logic [CW-1:0]    DEPTH_C = CW'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_TOP = PTR_W'(DEPTH - 1);

    // bytes waiting; equal pointers mean full only with overflow set
    function automatic logic [CW-1:0] waiting(input logic [PTR_W-1:0] wp,
                                              input logic [PTR_W-1:0] rp,
                                              input logic             ovf);
        logic [CW-1:0] w;
        logic [CW-1:0] r;
        w = CW'(wp);
        r = CW'(rp);
        if (wp > rp)
            return w - r;
        else if (wp < rp)
            return DEPTH_C - r + w;
        else
            return ovf ? DEPTH_C : '0;
    endfunction

    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic             avail_reg, avail_next;
    logic             ovf_reg, ovf_next;
    logic [CW-1:0]    remaining_reg, remaining_next;
    logic             clr_avail_reg, clr_avail_next;
    logic             out_valid_reg, out_valid_next;
    logic [BW-1:0]    out_byte_reg, out_byte_next;
    logic             out_dv_reg, out_dv_next;
    logic             out_last_reg, out_last_next;
    logic [CW-1:0]    out_fill_reg, out_fill_next;
    logic             out_ovf_reg, out_ovf_next;
    logic             out_avail_reg, out_avail_next;

    logic [PTR_W-1:0] wp_inc;
    logic [PTR_W-1:0] rp_inc;
    logic [CW-1:0]    rc_sat;
    logic [CW-1:0]    have;
    logic [CW-1:0]    take;
    logic             rc_nz;
    logic             ovf_push;
    logic             load;
    logic [PTR_W-1:0] rd_addr;
    logic [BW-1:0]    rd_data;

    assign wp_inc   = (wp_reg == PTR_TOP) ? '0 : wp_reg + 1'b1;
    assign rp_inc   = (rp_reg == PTR_TOP) ? '0 : rp_reg + 1'b1;
    assign rc_sat   = (request.read_count > DEPTH_C) ? DEPTH_C : request.read_count;
    assign rc_nz    = (request.read_count != '0);
    assign have     = waiting(wp_reg, rp_reg, ovf_reg);
    assign take     = (rc_sat < have) ? rc_sat : have;
    assign ovf_push = ovf_reg || (wp_inc == rp_reg);
    // re-read the current byte while stalled, fetch the next one on advance
    assign rd_addr  = cmd.emit ? rp_inc : rp_reg;

    urrb_ram #(
        .WIDTH (BW),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.push),
        .wr_addr (wp_reg),
        .wr_data (request.rx_byte),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        avail_next     = avail_reg;
        ovf_next       = ovf_reg;
        remaining_next = remaining_reg;
        clr_avail_next = clr_avail_reg;
        load           = 1'b0;
        out_byte_next  = out_byte_reg;
        out_dv_next    = out_dv_reg;
        out_last_next  = out_last_reg;
        out_fill_next  = out_fill_reg;
        out_ovf_next   = out_ovf_reg;
        out_avail_next = out_avail_reg;

        if (cmd.push)
        begin
            wp_next        = wp_inc;
            avail_next     = 1'b1;
            ovf_next       = ovf_push;
            load           = 1'b1;
            out_byte_next  = '0;
            out_dv_next    = 1'b0;
            out_last_next  = 1'b1;
            out_fill_next  = waiting(wp_inc, rp_reg, ovf_push);
            out_ovf_next   = ovf_push;
            out_avail_next = 1'b1;
        end
        else if (cmd.read_idle)
        begin
            // flag set but nothing waiting: drop the flag
            if (avail_reg && rc_nz)
            begin
                avail_next = 1'b0;
            end
            load           = 1'b1;
            out_byte_next  = '0;
            out_dv_next    = 1'b0;
            out_last_next  = 1'b1;
            out_fill_next  = have;
            out_ovf_next   = ovf_reg;
            out_avail_next = (avail_reg && rc_nz) ? 1'b0 : avail_reg;
        end
        else if (cmd.read_start)
        begin
            if (wp_reg == rp_reg)
            begin
                ovf_next = 1'b0;
            end
            remaining_next = take;
            clr_avail_next = (rc_sat >= have);
        end
        else if (cmd.emit)
        begin
            rp_next        = rp_inc;
            remaining_next = remaining_reg - 1'b1;
            if (sts.final_byte && clr_avail_reg)
            begin
                avail_next = 1'b0;
            end
            load           = 1'b1;
            out_byte_next  = rd_data;
            out_dv_next    = 1'b1;
            out_last_next  = sts.final_byte;
            out_fill_next  = waiting(wp_reg, rp_inc, ovf_reg);
            out_ovf_next   = ovf_reg;
            out_avail_next = (sts.final_byte && clr_avail_reg) ? 1'b0 : avail_reg;
        end

        if (load)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            rp_reg        <= '0;
            avail_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            remaining_reg <= '0;
            clr_avail_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            avail_reg     <= avail_next;
            ovf_reg       <= ovf_next;
            remaining_reg <= remaining_next;
            clr_avail_reg <= clr_avail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg  <= out_byte_next;
        out_dv_reg    <= out_dv_next;
        out_last_reg  <= out_last_next;
        out_fill_reg  <= out_fill_next;
        out_ovf_reg   <= out_ovf_next;
        out_avail_reg <= out_avail_next;
    end

    always_comb
    begin
        sts.in_valid   = request.valid;
        sts.is_read    = (request.command == urrb_pkg::CMD_READ);
        sts.out_free   = !out_valid_reg || result.ready;
        sts.read_go    = avail_reg && rc_nz && (have != '0);
        sts.final_byte = (remaining_reg == CW'(1));
    end

    assign request.ready         = cmd.in_ready;
    assign result.valid          = out_valid_reg;
    assign result.data_byte      = out_byte_reg;
    assign result.data_valid     = out_dv_reg;
    assign result.last           = out_last_reg;
    assign result.fill_level     = out_fill_reg;
    assign result.overflowed     = out_ovf_reg;
    assign result.data_available = out_avail_reg;

    `URRB_ASSERT(a_emit_has_bytes, cmd.emit |-> remaining_reg != '0)
    `URRB_ASSERT(a_read_len_in_range,
                 cmd.read_start |=> remaining_reg != '0 && remaining_reg <= DEPTH_C)
    `URRB_ASSERT_ALWAYS(a_ptrs_in_range,
                        !rst_n || (wp_reg <= PTR_TOP && rp_reg <= PTR_TOP))

endmodule

// ----- rtl/core/uart_rx_ring_buffer.sv -----
// ---------------------------------------------------------------------------
// uart_rx_ring_buffer
// Receive byte ring buffer with data-available and overflow flags.
// ---------------------------------------------------------------------------
//
//  Channel   Port     Role    Carries
//  -------   -------  ------  ------------------------------------------------
//  request   request  sink    command, rx_byte, read_count
//  result    result   source  data_byte, data_valid, last, fill_level,
//                             overflowed, data_available
//
//  A push yields one status item. A read is accepted while the store's
//  registered read port fetches the first byte; the read then emits
//  min(read_count, bytes waiting) bytes from the store, one after another.
//  A read with nothing to give yields a single status item.
//  The result register is freed as it is taken, so a new request is accepted
//  in the same cycle the previous item leaves, once a read's last byte is out.
//  A stall on the result side holds the current item and the read position.
//  Reset clears pointers and flags; the byte store is not cleared.
// ---------------------------------------------------------------------------
module uart_rx_ring_buffer #(
    parameter int DEPTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    urrb_in_if.sink    request,
    urrb_out_if.source result
);

    // command/status links between sequencer and datapath
    urrb_pkg::ctrl_cmd_t cmd;
    urrb_pkg::ctrl_sts_t sts;

    // sequencer: decides when to take an item and when to advance a read
    urrb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    // datapath: pointers, flags, byte store and the result register
    urrb_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .sts     (sts),
        .request (request),
        .result  (result)
    );

endmodule
